>>> hdl/bsm_pkg.sv
// Shared types and codes for the bank switch mapper.
package bsm_pkg;

   localparam int AddrWidth   = 16;
   localparam int DataWidth   = 8;
   localparam int CountWidth  = 9;
   localparam int OffsetWidth = 21;
   localparam int KindWidth   = 3;
   localparam int BankRegs    = 8;

   typedef enum logic [KindWidth-1:0] {
      REQ_WRITE = 3'd0,
      REQ_TICK  = 3'd1,
      REQ_PRG   = 3'd2,
      REQ_CHR   = 3'd3,
      REQ_NT    = 3'd4
   } req_kind_type;

   // register write decode, {addr[14:13], addr[0]}
   typedef enum logic [2:0] {
      WR_BANK_SELECT = 3'd0,
      WR_BANK_DATA   = 3'd1,
      WR_MIRROR      = 3'd2,
      WR_RAM_CTRL    = 3'd3,
      WR_IRQ_LATCH   = 3'd4,
      WR_IRQ_RELOAD  = 3'd5,
      WR_IRQ_DISABLE = 3'd6,
      WR_IRQ_ENABLE  = 3'd7
   } wr_decode_type;

   typedef enum logic [1:0] {
      CSR_PRG_COUNT   = 2'd0,
      CSR_CHR_COUNT   = 2'd1,
      CSR_FOUR_SCREEN = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CountWidth-1:0] prg_bank_count;
      logic [CountWidth-1:0] chr_bank_count;
      logic                  four_screen;
   } cfg_type;

   typedef struct packed {
      logic [KindWidth-1:0] req_type;
      logic [AddrWidth-1:0] addr;
      logic [DataWidth-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic [BankRegs-1:0][DataWidth-1:0] bank_regs;
      logic                               chr_swap_mode;
      logic                               prg_swap_mode;
      logic [2:0]                         bank_index;
      logic                               mirror_horizontal;
      logic                               ram_enable_bit;
      logic                               ram_protect_bit;
      logic [DataWidth-1:0]               line_counter;
      logic [DataWidth-1:0]               line_reload;
      logic                               irq_enabled;
      logic                               irq_pending;
   } mapper_state_type;

endpackage

>>> hdl/bsm_stream_if.sv
// Valid/ready channel interfaces for requests and responses.
interface bsm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [15:0] addr;
   logic [7:0]  value;

   modport source (output valid, req_type, addr, value, input ready);
   modport sink   (input valid, req_type, addr, value, output ready);
endinterface

interface bsm_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] mapped_offset;
   logic        out_of_range;
   logic        irq_line;
   logic        ram_enabled;
   logic        ram_protected;

   modport source (output valid, mapped_offset, out_of_range, irq_line, ram_enabled,
                   ram_protected, input ready);
   modport sink   (input valid, mapped_offset, out_of_range, irq_line, ram_enabled,
                   ram_protected, output ready);
endinterface

>>> hdl/bsm_state.sv
// Mapper register file, scanline counter and IRQ flags.
module bsm_state
   import bsm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             update,
   input  req_item_type     item,
   output mapper_state_type state_cur,
   output mapper_state_type state_nxt
);

   mapper_state_type state_ff;
   mapper_state_type state_in;
   mapper_state_type state_rst;
   logic [DataWidth-1:0] count_dec;
   wr_decode_type        decode;

   assign decode    = wr_decode_type'({item.addr[14:13], item.addr[0]});
   assign count_dec = state_ff.line_counter - 8'd1;

   // reset image: protect on, line counter at 255, rest zero
   always_comb begin
      state_rst                 = '0;
      state_rst.ram_protect_bit = 1'b1;
      state_rst.line_counter    = 8'hFF;
   end

   always_comb begin
      state_in = state_ff;
      case (item.req_type)
         REQ_WRITE: begin
            case (decode)
               WR_BANK_SELECT: begin
                  state_in.chr_swap_mode = item.value[7];
                  state_in.prg_swap_mode = item.value[6];
                  state_in.bank_index    = item.value[2:0];
               end
               WR_BANK_DATA:   state_in.bank_regs[state_ff.bank_index] = item.value;
               WR_MIRROR:      state_in.mirror_horizontal = item.value[0];
               WR_RAM_CTRL: begin
                  state_in.ram_enable_bit  = item.value[7];
                  state_in.ram_protect_bit = ~item.value[6];
               end
               WR_IRQ_LATCH:   state_in.line_reload  = item.value;
               WR_IRQ_RELOAD:  state_in.line_counter = state_ff.line_reload + 8'd1;
               WR_IRQ_DISABLE: begin
                  state_in.irq_enabled = 1'b0;
                  state_in.irq_pending = 1'b0;
               end
               WR_IRQ_ENABLE:  state_in.irq_enabled = 1'b1;
               default:        state_in.irq_enabled = 1'b1;
            endcase
         end
         REQ_TICK: begin
            if (count_dec == '0) begin
               state_in.line_counter = state_ff.line_reload;
               state_in.irq_pending  = 1'b1;
            end else begin
               state_in.line_counter = count_dec;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= state_rst;
      end else if (update) begin
         state_ff <= state_in;
      end
   end

   assign state_cur = state_ff;
   assign state_nxt = state_in;

endmodule

>>> hdl/bsm_xlate.sv
// PRG, CHR and nametable address translation.
module bsm_xlate
   import bsm_pkg::*;
(
   input  mapper_state_type         state,
   input  cfg_type                  cfg,
   input  req_item_type             item,
   output logic [OffsetWidth-1:0]   offset,
   output logic                     out_of_range
);

   logic [1:0]            prg_slot;
   logic [CountWidth-1:0] prg_bank;
   logic [CountWidth-1:0] prg_second_last;
   logic [CountWidth-1:0] prg_last;
   logic [2:0]            chr_slot;
   logic [2:0]            chr_reg_sel;
   logic [DataWidth-1:0]  chr_bank;
   logic [1:0]            nt_phys;

   assign prg_slot        = item.addr[14:13];
   assign prg_second_last = cfg.prg_bank_count - 9'd2;
   assign prg_last        = cfg.prg_bank_count - 9'd1;

   always_comb begin
      if (prg_slot == 2'd1)
         prg_bank = {1'b0, state.bank_regs[7]};
      else if (prg_slot == 2'd3)
         prg_bank = prg_last;
      else if ((prg_slot == 2'd0) == !state.prg_swap_mode)
         prg_bank = {1'b0, state.bank_regs[6]};
      else
         prg_bank = prg_second_last;
   end

   // slots 0..3 are two 2 KiB pairs, 4..7 map to regs 2..5
   assign chr_slot    = item.addr[12:10] ^ {state.chr_swap_mode, 2'b00};
   assign chr_reg_sel = chr_slot - 3'd2;
   assign chr_bank    = chr_slot[2] ? state.bank_regs[chr_reg_sel]
                      : {state.bank_regs[{2'b00, chr_slot[1]}][7:1], chr_slot[0]};

   always_comb begin
      if (cfg.four_screen)
         nt_phys = item.addr[11:10];
      else if (state.mirror_horizontal)
         nt_phys = {1'b0, item.addr[11]};
      else
         nt_phys = {1'b0, item.addr[10]};
   end

   always_comb begin
      offset       = '0;
      out_of_range = 1'b0;
      case (item.req_type)
         REQ_PRG: begin
            offset       = {prg_bank[7:0], item.addr[12:0]};
            out_of_range = (prg_bank >= cfg.prg_bank_count);
         end
         REQ_CHR: begin
            offset       = {3'b000, chr_bank, item.addr[9:0]};
            out_of_range = ({1'b0, chr_bank} >= cfg.chr_bank_count);
         end
         REQ_NT:  offset = {9'd0, nt_phys, item.addr[9:0]};
         default: ;
      endcase
   end

endmodule

>>> hdl/bank_switch_mapper_with_line_irq_unit.sv
// Bank switch mapper with scanline IRQ counter: top level.
// Takes one request per cycle while the response side accepts, and returns one response
// per request, in order. A request is captured into an input register on the req
// transfer; once the output register is free or being drained, the translation and
// the register/counter update are done in one pass and the response is loaded into
// the output register. A new request can be taken while the previous one moves on
// from the input register into the output register.
// Lookups (PRG, CHR, nametable) use the mapper state as it stands when the
// request reaches the execute stage, which already includes every earlier write
// and tick; the status bits (irq_line, ram_enabled, ram_protected) show the state
// after the request. Writes, ticks and unknown request types return a zero offset.
// The csr port sets bank counts and four-screen mode; the user must write it only while
// the block is idle, as the block itself does not enforce this.
module bank_switch_mapper_with_line_irq_unit
   import bsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   bsm_req_if.sink     req_ch,
   bsm_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata
);

   // configuration
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prg_bank_count <= 9'd2;
         cfg_ff.chr_bank_count <= 9'd8;
         cfg_ff.four_screen    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PRG_COUNT:   cfg_ff.prg_bank_count <= csr_wdata;
            CSR_CHR_COUNT:   cfg_ff.chr_bank_count <= csr_wdata;
            CSR_FOUR_SCREEN: cfg_ff.four_screen    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // input register
   logic         s1_valid_ff;
   req_item_type s1_item_ff;
   logic         s1_adv;
   logic         req_fire;

   // output register
   logic                   rsp_valid_ff;
   logic [OffsetWidth-1:0] rsp_offset_ff;
   logic                   rsp_oor_ff;
   logic                   rsp_irq_ff;
   logic                   rsp_ram_en_ff;
   logic                   rsp_ram_prot_ff;

   // execute stage moves when the output register is free or being drained
   assign s1_adv       = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff.req_type <= req_ch.req_type;
         s1_item_ff.addr     <= req_ch.addr;
         s1_item_ff.value    <= req_ch.value;
      end
   end

   // mapper state and translation
   mapper_state_type state_cur;
   mapper_state_type state_nxt;
   logic [OffsetWidth-1:0] xl_offset;
   logic                   xl_oor;

   bsm_state u_state (
      .clock     (clock),
      .reset     (reset),
      .update    (s1_adv),
      .item      (s1_item_ff),
      .state_cur (state_cur),
      .state_nxt (state_nxt)
   );

   bsm_xlate u_xlate (
      .state        (state_cur),
      .cfg          (cfg_ff),
      .item         (s1_item_ff),
      .offset       (xl_offset),
      .out_of_range (xl_oor)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_offset_ff   <= xl_offset;
         rsp_oor_ff      <= xl_oor;
         rsp_irq_ff      <= state_nxt.irq_pending & state_nxt.irq_enabled;
         rsp_ram_en_ff   <= state_nxt.ram_enable_bit;
         rsp_ram_prot_ff <= state_nxt.ram_protect_bit;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.mapped_offset = rsp_offset_ff;
   assign rsp_ch.out_of_range  = rsp_oor_ff;
   assign rsp_ch.irq_line      = rsp_irq_ff;
   assign rsp_ch.ram_enabled   = rsp_ram_en_ff;
   assign rsp_ch.ram_protected = rsp_ram_prot_ff;

   // pending IRQ only gets set by a tick that reaches execute
   a_pending_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(state_cur.irq_pending) |->
         $past(s1_adv) && ($past(s1_item_ff.req_type) == REQ_TICK))
      else $error("irq_pending set without a scanline tick");

   // mapper state moves only when a request leaves the execute stage
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_adv |=> $stable(state_cur))
      else $error("mapper state changed without a request");

   // a nametable lookup never flags out of range
   a_nt_in_range: assert property (@(posedge clock) disable iff (reset)
      s1_adv && (s1_item_ff.req_type == REQ_NT) |=> !rsp_oor_ff)
      else $error("nametable lookup flagged out of range");

   // an empty execute stage never blocks the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ch.ready)
      else $error("input stalled with empty execute stage");

endmodule
